// ===== hw/rtl/mpfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpfe_pkg
// Shared types, constants and fixed-point helpers for the model potential
// force evaluator.
// ----------------------------------------------------------------------------
package mpfe_pkg;

    // Fixed-point format and projection limit
    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 3;

    // Potential type codes
    localparam logic [2:0] POT_HARM  = 3'd1;
    localparam logic [2:0] POT_ANH   = 3'd2;
    localparam logic [2:0] POT_QUART = 3'd3;
    localparam logic [2:0] POT_MORSE = 3'd4;
    localparam logic [2:0] POT_SET2  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_POT_TYPE = 2'd0;
    localparam logic [1:0] CFG_R_EQ     = 2'd1;
    localparam logic [1:0] CFG_DIM      = 2'd2;

    // Coefficients in Q30
    localparam logic [30:0] C_HALF    = 31'd536870912;
    localparam logic [30:0] C_0P1     = 31'd107374182;
    localparam logic [30:0] C_0P01    = 31'd10737418;
    localparam logic [30:0] C_0P25    = 31'd268435456;
    localparam logic [30:0] C_0P3     = 31'd322122547;
    localparam logic [30:0] C_0P04    = 31'd42949673;
    localparam logic [30:0] C_MORSE_D = 31'd201305117;
    localparam logic [30:0] C_MORSE_A = 31'd1246077387;
    localparam logic [30:0] C_MORSE_F = 31'd467229177;
    localparam logic [30:0] C_5_E3    = 31'd649613804;
    localparam logic [30:0] C_5_E4    = 31'd458519076;
    localparam logic [30:0] C_5_F2    = 31'd1948841411;
    localparam logic [30:0] C_5_F3    = 31'd1834076305;
    localparam logic [30:0] C_LOG2E   = 31'd1549082005;

    // 2^f polynomial, ln2^n/n! for n = 1..6, Q30
    localparam logic [31:0] EXP_POLY [6] = '{
        32'd744261118, 32'd257941248, 32'd59597083,
        32'd10327388, 32'd1431680, 32'd165394
    };

    // Input transaction
    typedef struct packed {
        logic [30:0]        radius;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
        logic signed [31:0] force_in_x;
        logic signed [31:0] force_in_y;
        logic signed [31:0] force_in_z;
        logic               last_particle;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic signed [31:0] scalar_force;
        logic signed [31:0] force_out_x;
        logic signed [31:0] force_out_y;
        logic signed [31:0] force_out_z;
        logic signed [31:0] energy;
        logic               last_out;
        logic               div_fault;
    } t_out;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturating add and subtract
    function automatic logic signed [31:0] f_sadd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return f_sat(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] f_ssub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return f_sat(66'(a) - 66'(b));
    endfunction

    // Product of two values, rounded half up, saturated
    function automatic logic signed [31:0] f_qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        p = p + (66'sd1 <<< (FRAC_BITS - 1));
        return f_sat(p >>> FRAC_BITS);
    endfunction

    // Q30 coefficient times value, rounded half up, saturated
    function automatic logic signed [31:0] f_cmul(input logic [30:0] c,
                                                 input logic signed [31:0] x);
        logic signed [65:0] p;
        p = 66'($signed({1'b0, c})) * 66'(x);
        p = p + (66'sd1 <<< 29);
        return f_sat(p >>> 30);
    endfunction

endpackage : mpfe_pkg
`default_nettype wire

// ===== hw/rtl/model_potential_force_eval_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// model_potential_force_eval_unit
// Streaming model-potential evaluator: energy, radial force and projected
// force update for one particle per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one particle (t_in). Output
//   channel o_valid / i_stall returns one result (t_out) per particle, in
//   order. A transaction moves at a clock edge with valid high, stall low.
//   Configuration (pot_type, r_eq, dim) is written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while no particle is in flight.
//   Throughput: one particle per cycle, sustained while the receiver does not stall.
//   The pipeline length is set by the Horner chain of the exponential (six
//   multiply stages) and, mostly, by the restoring divider of the projection,
//   one quotient bit per stage over 32 stages.
//   A stall from the receiver holds the output register; empty stages
//   upstream keep filling, and o_stall rises only once every stage is full.
//   Reset clears all stage valid bits and loads the register defaults:
//   harmonic potential, r_eq = 1.0, dim = 1.
// ----------------------------------------------------------------------------
module model_potential_force_eval_unit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  mpfe_pkg::t_in   i_data,
    output logic            o_valid,
    input  wire             i_stall,
    output mpfe_pkg::t_out  o_data,
    input  wire             i_cfg_we,
    input  wire  [1:0]      i_cfg_idx,
    input  wire  [30:0]     i_cfg_data
);
    import mpfe_pkg::*;

    localparam int S_DIV = 16;
    localparam int S_FIN = S_DIV + 32;
    localparam int NSTG  = S_FIN + 1;

    typedef struct packed {
        logic [30:0]             rad;
        logic [2:0][31:0]        comp;
        logic [2:0][31:0]        frc;
        logic                    last;
        logic signed [31:0]      d;
        logic signed [31:0]      d2;
        logic signed [31:0]      d3;
        logic signed [31:0]      d4;
        logic signed [31:0]      xy;
        logic signed [31:0]      h;
        logic signed [31:0]      e3;
        logic signed [31:0]      e4;
        logic signed [31:0]      q4;
        logic signed [31:0]      f2;
        logic signed [31:0]      f3;
        logic signed [31:0]      pen;
        logic signed [31:0]      pfs;
        logic signed [31:0]      k;
        logic [29:0]             f30;
        logic [31:0]             acc;
        logic signed [31:0]      e;
        logic signed [31:0]      u;
        logic signed [31:0]      uu;
        logic signed [31:0]      ue;
        logic signed [31:0]      en;
        logic signed [31:0]      fs;
        logic [2:0][63:0]        num;
        logic [2:0][30:0]        rem;
        logic [2:0][31:0]        q;
        logic [2:0]              ovf;
        logic [2:0]              neg;
        logic                    fault;
    } t_stg;

    logic [2:0]      r_pot_type;
    logic [30:0]     r_r_eq;
    logic [1:0]      r_dim;
    t_stg            r_stg [NSTG];
    t_stg            n_stg [NSTG];
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot_type <= POT_HARM;
            r_r_eq     <= 31'd65536;
            r_dim      <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POT_TYPE: r_pot_type <= i_cfg_data[2:0];
                CFG_R_EQ:     r_r_eq     <= i_cfg_data;
                CFG_DIM:      r_dim      <= i_cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    // Advance a stage when it or any stage after it is empty, or the sink takes
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            stg_en[k] = !i_stall || ((~r_vld >> k) != '0);
        end
    end

    assign o_stall = !stg_en[0];
    assign o_valid = r_vld[NSTG-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (stg_en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Stage datapath
    always_comb begin
        logic [31:0]        r2;
        logic [63:0]        prod;
        logic signed [33:0] sh;
        logic [63:0]        t64;
        logic [31:0]        mc;
        logic [31:0]        mf;
        logic [32:0]        qc;
        logic signed [65:0] val;
        logic [1:0]         dim_n;
        logic               use5;

        // default: carry each stage forward
        n_stg[0] = r_stg[0];
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];
        end
        use5 = (r_pot_type == POT_SET2);
        t64  = '0;
        qc   = '0;
        val  = '0;

        // capture the particle, form the displacement
        n_stg[0].rad     = i_data.radius;
        n_stg[0].comp[0] = i_data.comp_x;
        n_stg[0].comp[1] = i_data.comp_y;
        n_stg[0].comp[2] = i_data.comp_z;
        n_stg[0].frc[0]  = i_data.force_in_x;
        n_stg[0].frc[1]  = i_data.force_in_y;
        n_stg[0].frc[2]  = i_data.force_in_z;
        n_stg[0].last    = i_data.last_particle;
        n_stg[0].fault   = 1'b0;
        n_stg[0].d       = $signed(32'({1'b0, i_data.radius}) - 32'({1'b0, r_r_eq}));

        // square and Morse exponent argument
        n_stg[1].d2 = f_qmul(r_stg[0].d, r_stg[0].d);
        n_stg[1].xy = f_sat(-66'(f_cmul(C_MORSE_A, r_stg[0].d)));

        // cube, fourth power, base-two exponent
        n_stg[2].d3 = f_qmul(r_stg[1].d2, r_stg[1].d);
        n_stg[2].d4 = f_qmul(r_stg[1].d2, r_stg[1].d2);
        n_stg[2].xy = f_cmul(C_LOG2E, r_stg[1].xy);

        // polynomial terms; split exponent into integer and fraction
        n_stg[3].h   = f_cmul(C_HALF, r_stg[2].d2);
        n_stg[3].e3  = f_cmul(use5 ? C_5_E3 : C_0P1, r_stg[2].d3);
        n_stg[3].e4  = f_cmul(use5 ? C_5_E4 : C_0P01, r_stg[2].d4);
        n_stg[3].q4  = f_cmul(C_0P25, r_stg[2].d4);
        n_stg[3].f2  = f_cmul(use5 ? C_5_F2 : C_0P3, r_stg[2].d2);
        n_stg[3].f3  = f_cmul(use5 ? C_5_F3 : C_0P04, r_stg[2].d3);
        n_stg[3].k   = r_stg[2].xy >>> FRAC_BITS;
        n_stg[3].f30 = 30'(32'(r_stg[2].xy[FRAC_BITS-1:0]) << (30 - FRAC_BITS));
        n_stg[3].acc = EXP_POLY[5];

        // polynomial energy and force
        case (r_pot_type)
            POT_HARM: begin
                n_stg[4].pen = r_stg[3].h;
                n_stg[4].pfs = f_sat(-66'(r_stg[3].d));
            end
            POT_ANH, POT_SET2: begin
                n_stg[4].pen = f_sadd(f_sadd(r_stg[3].h, r_stg[3].e3), r_stg[3].e4);
                n_stg[4].pfs = f_ssub(f_ssub(f_sat(-66'(r_stg[3].d)), r_stg[3].f2),
                                      r_stg[3].f3);
            end
            POT_QUART: begin
                n_stg[4].pen = r_stg[3].q4;
                n_stg[4].pfs = f_sat(-66'(r_stg[3].d3));
            end
            default: begin
                n_stg[4].pen = '0;
                n_stg[4].pfs = '0;
            end
        endcase

        // Horner steps of 2^f, one coefficient per stage
        for (int m = 0; m < 5; m++) begin
            prod = 64'(r_stg[3+m].acc) * 64'(r_stg[3+m].f30) + (64'd1 << 29);
            n_stg[4+m].acc = EXP_POLY[4-m] + 32'(prod >> 30);
        end
        prod = 64'(r_stg[8].acc) * 64'(r_stg[8].f30) + (64'd1 << 29);
        n_stg[9].acc = (32'd1 << 30) + 32'(prod >> 30);

        // scale by 2^k
        sh = 34'(30 - FRAC_BITS) - 34'(r_stg[9].k);
        if (sh < 0) begin
            n_stg[10].e = 32'sh7FFFFFFF;
        end else if (sh == 0) begin
            n_stg[10].e = f_sat($signed(66'({34'd0, r_stg[9].acc})));
        end else if (sh > 34'sd62) begin
            n_stg[10].e = '0;
        end else begin
            t64 = 64'(r_stg[9].acc) + (64'd1 << (sh[5:0] - 6'd1));
            n_stg[10].e = $signed(32'(t64 >> sh[5:0]));
        end

        // Morse terms
        n_stg[11].u  = f_ssub(32'sd1 <<< FRAC_BITS, r_stg[10].e);
        n_stg[12].uu = f_qmul(r_stg[11].u, r_stg[11].u);
        n_stg[12].ue = f_qmul(r_stg[11].u, r_stg[11].e);

        // select energy and scalar force
        if (r_pot_type == POT_MORSE) begin
            n_stg[13].en = f_cmul(C_MORSE_D, r_stg[12].uu);
            n_stg[13].fs = f_sat(-66'(f_cmul(C_MORSE_F, r_stg[12].ue)));
        end else begin
            n_stg[13].en = r_stg[12].pen;
            n_stg[13].fs = r_stg[12].pfs;
        end

        // magnitude products for the projection
        for (int j = 0; j < 3; j++) begin
            mc = r_stg[13].comp[j][31] ? 32'(-r_stg[13].comp[j]) : r_stg[13].comp[j];
            mf = r_stg[13].fs[31] ? 32'(-r_stg[13].fs) : r_stg[13].fs;
            n_stg[14].num[j] = 64'(mc) * 64'(mf);
            n_stg[14].neg[j] = r_stg[13].comp[j][31] ^ r_stg[13].fs[31];
        end

        // add half divisor for rounding, flag quotient overflow
        for (int j = 0; j < 3; j++) begin
            t64 = r_stg[14].num[j] + 64'(r_stg[14].rad >> 1);
            n_stg[15].num[j] = t64;
            n_stg[15].rem[j] = t64[62:32];
            n_stg[15].ovf[j] = (t64[62:32] >= r_stg[14].rad);
            n_stg[15].q[j]   = '0;
        end

        // restoring division, one quotient bit per stage
        for (int s = 0; s < 32; s++) begin
            for (int j = 0; j < 3; j++) begin
                r2 = {r_stg[S_DIV+s-1].rem[j], r_stg[S_DIV+s-1].num[j][31]};
                if (r2 >= {1'b0, r_stg[S_DIV+s-1].rad}) begin
                    n_stg[S_DIV+s].rem[j] = 31'(r2 - {1'b0, r_stg[S_DIV+s-1].rad});
                    n_stg[S_DIV+s].q[j]   = {r_stg[S_DIV+s-1].q[j][30:0], 1'b1};
                end else begin
                    n_stg[S_DIV+s].rem[j] = r2[30:0];
                    n_stg[S_DIV+s].q[j]   = {r_stg[S_DIV+s-1].q[j][30:0], 1'b0};
                end
                n_stg[S_DIV+s].num[j] = {r_stg[S_DIV+s-1].num[j][62:0], 1'b0};
            end
        end

        // clamp quotients, sign them and update the force
        dim_n = (32'(r_dim) > 32'(MAX_DIM)) ? 2'(MAX_DIM) : r_dim;
        if (r_dim > 2'd1) begin
            if (r_stg[S_FIN-1].rad == '0) begin
                n_stg[S_FIN].fault = 1'b1;
            end else begin
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) < dim_n) begin
                        if (r_stg[S_FIN-1].ovf[j] || r_stg[S_FIN-1].q[j] > 32'h80000000) begin
                            qc = 33'h080000000;
                        end else begin
                            qc = {1'b0, r_stg[S_FIN-1].q[j]};
                        end
                        val = r_stg[S_FIN-1].neg[j] ? -$signed(66'(qc)) : $signed(66'(qc));
                        n_stg[S_FIN].frc[j] = f_sadd(r_stg[S_FIN-1].frc[j], f_sat(val));
                    end
                end
            end
        end else begin
            n_stg[S_FIN].frc[0] = f_sadd(r_stg[S_FIN-1].frc[0], r_stg[S_FIN-1].fs);
        end
    end

    // Result transaction
    assign o_data.scalar_force = r_stg[NSTG-1].fs;
    assign o_data.force_out_x  = r_stg[NSTG-1].frc[0];
    assign o_data.force_out_y  = r_stg[NSTG-1].frc[1];
    assign o_data.force_out_z  = r_stg[NSTG-1].frc[2];
    assign o_data.energy       = r_stg[NSTG-1].en;
    assign o_data.last_out     = r_stg[NSTG-1].last;
    assign o_data.div_fault    = r_stg[NSTG-1].fault;

endmodule : model_potential_force_eval_unit
`default_nettype wire

// ===== hw/rtl/mpfe_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpfe_chk
// Port-level checks for the force evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module mpfe_chk (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_valid,
    input wire            o_stall,
    input mpfe_pkg::t_in  i_data,
    input wire            o_valid,
    input wire            i_stall,
    input mpfe_pkg::t_out o_data,
    input wire            i_cfg_we,
    input wire [1:0]      i_cfg_idx,
    input wire [30:0]     i_cfg_data
);
    import mpfe_pkg::*;

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // Back-pressure only when the output itself is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // Never stall the source in a cycle where the sink takes results
    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled with sink ready");

endmodule : mpfe_chk

bind model_potential_force_eval_unit mpfe_chk u_mpfe_chk (.*);
`default_nettype wire

// ===== dv/mpfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfe_checker
// Watches both channels and the configuration port of the force evaluator,
// predicts each result from the accepted particle and compares it in order.
// ----------------------------------------------------------------------------
module mpfe_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_in_stall,
    input  mpfe_pkg::t_in   i_in_data,
    input  wire             i_out_valid,
    input  wire             i_out_stall,
    input  mpfe_pkg::t_out  i_out_data,
    input  wire             i_cfg_we,
    input  wire  [1:0]      i_cfg_idx,
    input  wire  [30:0]     i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    import mpfe_pkg::*;

    // Shadow copy of the configuration registers
    logic [2:0]  pot_sh;
    logic [30:0] req_sh;
    logic [1:0]  dim_sh;

    t_out expected_results[$];

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    function automatic longint clamp32(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // Round half up, then drop s bits (arithmetic shift floors)
    function automatic longint rnd_shr(input longint p, input int s);
        return (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint vprod(input longint a, input longint b);
        return clamp32(rnd_shr(a * b, FRAC_BITS));
    endfunction

    function automatic longint kprod(input logic [30:0] c, input longint x);
        return clamp32(rnd_shr(longint'(c) * x, 30));
    endfunction

    // 2^(x*log2e) with a degree-6 polynomial for the fraction
    function automatic longint exp_fixed(input longint x);
        longint y, k, f, s;
        longint unsigned f30, acc, p;
        y = kprod(C_LOG2E, x);
        k = y >>> FRAC_BITS;
        f = y - (k <<< FRAC_BITS);
        f30 = longint'(f) << (30 - FRAC_BITS);
        acc = EXP_POLY[5];
        for (int i = 4; i >= 0; i--) begin
            acc = EXP_POLY[i] + ((acc * f30 + (64'd1 << 29)) >> 30);
        end
        p = (64'd1 << 30) + ((acc * f30 + (64'd1 << 29)) >> 30);
        s = k + FRAC_BITS - 30;
        if (s > 0) return QMAX;
        if (s == 0) return clamp32(longint'(p));
        if (s < -62) return 0;
        return longint'((p + (64'd1 << (-s - 1))) >> (-s));
    endfunction

    // comp * fs / rad on magnitudes, nearest with ties away from zero
    function automatic longint project_term(input longint comp, input longint fs,
                                            input longint rad);
        longint unsigned mc, mf, q;
        mc = (comp < 0) ? -comp : comp;
        mf = (fs < 0) ? -fs : fs;
        q = (mc * mf + longint'(rad) / 2) / longint'(rad);
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        return clamp32(((comp < 0) != (fs < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_out predict_force(input t_in p);
        t_out   r;
        longint rad, d, d2, d3, d4, e, u, fs, en;
        longint comp [3];
        longint frc [3];
        int     n;
        rad = longint'(p.radius);
        comp[0] = p.comp_x;      comp[1] = p.comp_y;      comp[2] = p.comp_z;
        frc[0]  = p.force_in_x;  frc[1]  = p.force_in_y;  frc[2]  = p.force_in_z;
        fs = 0;
        en = 0;
        r.div_fault = 1'b0;
        d  = rad - longint'(req_sh);
        d2 = vprod(d, d);
        d3 = vprod(d2, d);
        d4 = vprod(d2, d2);
        case (pot_sh)
            POT_HARM: begin
                en = kprod(C_HALF, d2);
                fs = clamp32(-d);
            end
            POT_ANH: begin
                en = clamp32(clamp32(kprod(C_HALF, d2) + kprod(C_0P1, d3))
                             + kprod(C_0P01, d4));
                fs = clamp32(clamp32(clamp32(-d) - kprod(C_0P3, d2)) - kprod(C_0P04, d3));
            end
            POT_QUART: begin
                en = kprod(C_0P25, d4);
                fs = clamp32(-d3);
            end
            POT_MORSE: begin
                e  = exp_fixed(clamp32(-kprod(C_MORSE_A, d)));
                u  = clamp32((64'sd1 <<< FRAC_BITS) - e);
                en = kprod(C_MORSE_D, vprod(u, u));
                fs = clamp32(-kprod(C_MORSE_F, vprod(u, e)));
            end
            POT_SET2: begin
                en = clamp32(clamp32(kprod(C_HALF, d2) + kprod(C_5_E3, d3))
                             + kprod(C_5_E4, d4));
                fs = clamp32(clamp32(clamp32(-d) - kprod(C_5_F2, d2)) - kprod(C_5_F3, d3));
            end
            default: ;
        endcase
        if (dim_sh > 1) begin
            if (rad == 0) begin
                r.div_fault = 1'b1;
            end else begin
                n = (dim_sh < MAX_DIM) ? dim_sh : MAX_DIM;
                for (int j = 0; j < n; j++) begin
                    frc[j] = clamp32(frc[j] + project_term(comp[j], fs, rad));
                end
            end
        end else begin
            frc[0] = clamp32(frc[0] + fs);
        end
        r.scalar_force = fs[31:0];
        r.force_out_x  = frc[0][31:0];
        r.force_out_y  = frc[1][31:0];
        r.force_out_z  = frc[2][31:0];
        r.energy       = en[31:0];
        r.last_out     = p.last_particle;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pot_sh <= POT_HARM;
            req_sh <= 31'd65536;
            dim_sh <= 2'd1;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_force(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.scalar_force !== want.scalar_force)
                        report_mismatch("scalar_force", i_out_data.scalar_force,
                                        want.scalar_force);
                    if (i_out_data.force_out_x !== want.force_out_x)
                        report_mismatch("force_out_x", i_out_data.force_out_x,
                                        want.force_out_x);
                    if (i_out_data.force_out_y !== want.force_out_y)
                        report_mismatch("force_out_y", i_out_data.force_out_y,
                                        want.force_out_y);
                    if (i_out_data.force_out_z !== want.force_out_z)
                        report_mismatch("force_out_z", i_out_data.force_out_z,
                                        want.force_out_z);
                    if (i_out_data.energy !== want.energy)
                        report_mismatch("energy", i_out_data.energy, want.energy);
                    if (i_out_data.last_out !== want.last_out)
                        report_mismatch("last_out", i_out_data.last_out, want.last_out);
                    if (i_out_data.div_fault !== want.div_fault)
                        report_mismatch("div_fault", i_out_data.div_fault, want.div_fault);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POT_TYPE: pot_sh <= i_cfg_data[2:0];
                    CFG_R_EQ:     req_sh <= i_cfg_data;
                    CFG_DIM:      dim_sh <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives particles and configuration into the force evaluator with random
// gaps and back-pressure; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;
    import mpfe_pkg::*;

    localparam int WAIT_LAT = 70;
    localparam int WD_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_POT_TYPE;
    logic [30:0] cfg_data = '0;
    t_in         in_data = '0;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    logic [30:0] cur_req = 31'd65536;

    always #5 i_clk = ~i_clk;

    model_potential_force_eval_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    mpfe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Stall the result channel for a drawn number of cycles per transaction
    initial begin
        int g;
        forever begin
            g = draw_gap();
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Drop valid and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0 || out_valid) @(negedge i_clk);
        repeat (WAIT_LAT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_R_EQ) cur_req = val;
        @(negedge i_clk);
    endtask

    task automatic setup(input logic [2:0] pot, input logic [30:0] req, input logic [1:0] dm);
        drain();
        write_reg(CFG_POT_TYPE, {28'd0, pot});
        write_reg(CFG_R_EQ, req);
        write_reg(CFG_DIM, {29'd0, dm});
        cfg_we <= 1'b0;
    endtask

    // Hold valid with a stable payload until the block takes it
    task automatic send(input t_in p);
        int g;
        g = draw_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            3: return 32'(int'($urandom_range(0, 524288)) - 262144);
            default: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
        endcase
    endfunction

    function automatic t_in rand_particle();
        t_in    p;
        longint r;
        case ($urandom_range(0, 9))
            0: r = $urandom() & 32'h7FFFFFFF;
            1: r = 0;
            2: r = 31'h7FFFFFFF;
            default: r = longint'(cur_req) + $urandom_range(0, 524288) - 262144;
        endcase
        if (r < 0) r = 0;
        if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
        p.radius        = r[30:0];
        p.comp_x        = rand_word();
        p.comp_y        = rand_word();
        p.comp_z        = rand_word();
        p.force_in_x    = rand_word();
        p.force_in_y    = rand_word();
        p.force_in_z    = rand_word();
        p.last_particle = $urandom_range(0, 1);
        return p;
    endfunction

    function automatic t_in mk(input logic [30:0] rad, input logic [31:0] c,
                               input logic [31:0] f, input logic last);
        t_in p;
        p.radius = rad;
        p.comp_x = c;   p.comp_y = -c;   p.comp_z = c;
        p.force_in_x = f;   p.force_in_y = f;   p.force_in_z = -f;
        p.last_particle = last;
        return p;
    endfunction

    initial begin
        logic [30:0] req;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, field extremes
        calm = 1'b1;
        send(mk(31'd65536, 32'h00010000, 32'd0, 1'b0));
        send(mk(31'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
        send(mk(31'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0));
        // Every potential with full projection
        for (int t = POT_HARM; t <= POT_SET2; t++) begin
            setup(t[2:0], 31'd65536, 2'd3);
            send(mk(31'd98304, 32'h00018000, 32'd1000, 1'b1));
            send(mk(31'd32768, 32'hFFFF8000, 32'h7FFFFFF0, 1'b0));
            send(mk(31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1));
        end
        // Zero radius with projection: fault, force unchanged
        send(mk(31'd0, 32'h00010000, 32'h12345678, 1'b0));
        // Unknown potential types
        setup(3'd0, 31'd0, 2'd2);
        send(mk(31'd65536, 32'h00010000, 32'd77, 1'b1));
        setup(3'd7, 31'h7FFFFFFF, 2'd0);
        send(mk(31'd0, 32'h80000000, 32'h7FFFFFFF, 1'b0));
        setup(3'd6, 31'd65536, 2'd1);
        send(mk(31'd131072, 32'd5, 32'd5, 1'b1));

        // Random phases with changing settings
        for (int ph = 0; ph < 16; ph++) begin
            case ($urandom_range(0, 4))
                0: req = 31'd0;
                1: req = 31'h7FFFFFFF;
                2: req = 31'd65536;
                3: req = $urandom() & 31'h7FFFFFFF;
                default: req = $urandom_range(0, 524288);
            endcase
            setup(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 5)),
                  req, 2'($urandom_range(0, 3)));
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 106; n++) begin
                // Hold off once until the pipeline has emptied
                if (ph == 3 && n == 50) begin
                    drain();
                end
                send(rand_particle());
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
